// ----- design/slfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfe_pkg
// shared types, codes and constants of the sensor link frame engine
// ----------------------------------------------------------------------------
package slfe_pkg;

    localparam int RX_BUFFER_BYTES_DEF = 24;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int COUNT_W      = 6;
    localparam int FRAME_BYTES  = 24;
    localparam int HEAD_WORDS   = 5;
    localparam int HEAD_BYTES   = 10;
    localparam int IN_DATA_W    = 112;
    localparam int OUT_DATA_W   = 80;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_RX   = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic OUT_TX      = 1'b0;
    localparam logic OUT_OUTCOME = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CHECKSUM  = 3'd1;
    localparam logic [2:0] ST_DEV_ERROR = 3'd2;
    localparam logic [2:0] ST_TIMEOUT   = 3'd3;
    localparam logic [2:0] ST_DATA      = 3'd4;
    localparam logic [2:0] ST_OTHER     = 3'd5;

    localparam logic [7:0]  SYNC0       = 8'h55;
    localparam logic [7:0]  SYNC1       = 8'hAA;
    localparam logic [15:0] HEAD_RESP   = 16'h55AA;
    localparam logic [15:0] HEAD_DATA   = 16'h5AA5;
    localparam logic [7:0]  IDLE_GAP_RESET = 8'd5;
    localparam logic [3:0]  MAX_PARAMS  = 4'd8;

    typedef struct packed {
        logic        is_outcome;
        logic [2:0]  status;
        logic [15:0] code;
        logic [3:0]  count;
        logic [63:0] data;
    } slfe_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } slfe_q_status_t;

endpackage
`default_nettype wire

// ----- design/sensor_link_frame_engine_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_link_frame_engine_top
// frames commands for a serial sensor module and checks its responses
// ----------------------------------------------------------------------------
// s_* takes one word per cycle: a send command, a received byte or a 1 ms
// tick, selected by s_tuser. the front part updates the receiver and timeout
// state in the cycle a word is taken and queues a job for each send (24
// frame bytes) and each tick that ends a response (one outcome word).
// m_* gives frame bytes (m_tuser 0, tlast on byte 23) and outcome words
// (m_tuser 1, tlast set). the back part emits one result per cycle while
// m_tready is high and a job waits, from a registered output; a word's first
// result passes the job queue and the output register to reach m_tvalid.
// a send occupies the back part for its 24 frame bytes, an outcome for one word.
// s_tready drops only while the job queue is full (QUEUE_DEPTH jobs), which
// happens when sends come faster than their 24 bytes drain or m_tready is
// held low; bytes and ticks are then held off as well. cfg_* writes the idle
// gap setting and is always ready.
// reset clears the control and receiver state, empties the queue and sets the idle gap to 5.
// ----------------------------------------------------------------------------
module sensor_link_frame_engine_top #(
    parameter int RX_BUFFER_BYTES = slfe_pkg::RX_BUFFER_BYTES_DEF,
    parameter int QUEUE_DEPTH     = slfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_data,       // idle_gap_ticks
    input  wire         s_tvalid,
    output logic        s_tready,
    // command_code[15:0], param_count[19:16], param_bytes[83:20],
    // timeout_ticks[97:84], rx_byte[105:98], zero fill
    input  wire  [slfe_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire  [1:0]  s_tuser,        // kind[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    // tx_byte[7:0], status[10:8], response_code[26:11], response_length[42:27],
    // result_code[58:43], payload_word[74:59], zero fill
    output logic [slfe_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]  m_tuser,        // out_kind[0]
    output logic        m_tlast
);

    slfe_pkg::slfe_job_t      push_job;
    slfe_pkg::slfe_job_t      head_job;
    slfe_pkg::slfe_q_status_t q_stat;
    logic                     push;
    logic                     pop;
    logic                     s_accept;
    logic                     out_user;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tuser   = out_user;

    slfe_front #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_gap       (cfg_data),
        .accept        (s_accept),
        .kind          (s_tuser),
        .command_code  (s_tdata[15:0]),
        .param_count   (s_tdata[19:16]),
        .param_bytes   (s_tdata[83:20]),
        .timeout_ticks (s_tdata[97:84]),
        .rx_byte       (s_tdata[105:98]),
        .push          (push),
        .push_job      (push_job)
    );

    slfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_stat)
    );

    slfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (out_user),
        .out_last  (m_tlast)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("job queue overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty job queue");

    a_outcome_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata[7:0] == 8'd0))
        else $error("outcome word without last or with tx byte");

    a_push_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_stat.empty)
        else $error("queued job lost");

endmodule
`default_nettype wire

// ----- design/slfe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfe_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module slfe_queue #(
    parameter int DEPTH = slfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  slfe_pkg::slfe_job_t      push_job,
    input  wire                      pop,
    output slfe_pkg::slfe_job_t      head_job,
    output slfe_pkg::slfe_q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slfe_pkg::slfe_job_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push  = push && !q_status.full;
    assign do_pop   = pop && !q_status.empty;
    assign head_job = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ----- design/slfe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfe_front
// accepts words, tracks receiver and timeout state, queues frame and outcome jobs
// ----------------------------------------------------------------------------
module slfe_front #(
    parameter int RX_BUFFER_BYTES = slfe_pkg::RX_BUFFER_BYTES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_write,
    input  wire  [7:0]          cfg_gap,
    input  wire                 accept,
    input  wire  [1:0]          kind,
    input  wire  [15:0]         command_code,
    input  wire  [3:0]          param_count,
    input  wire  [63:0]         param_bytes,
    input  wire  [13:0]         timeout_ticks,
    input  wire  [7:0]          rx_byte,
    output logic                push,
    output slfe_pkg::slfe_job_t push_job
);

    localparam int CW = slfe_pkg::COUNT_W;

    logic [7:0]    idle_gap_reg, idle_gap_next;
    logic          waiting_reg, waiting_next;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [15:0]   running_sum_reg, running_sum_next;
    logic [7:0]    newest_reg, newest_next;
    logic [7:0]    previous_reg, previous_next;
    logic [15:0]   head_reg [slfe_pkg::HEAD_WORDS];
    logic [15:0]   head_next [slfe_pkg::HEAD_WORDS];
    logic [7:0]    gap_reg, gap_next;
    logic [13:0]   elapsed_reg, elapsed_next;
    logic [13:0]   armed_reg, armed_next;

    logic [3:0]    count_sat;
    logic [63:0]   params_masked;
    logic [15:0]   expect_sum;
    logic [7:0]    gap_inc;
    logic [2:0]    frame_status;
    logic [63:0]   frame_words;
    logic          clear_rx;

    always_comb
    begin
        count_sat = (param_count > slfe_pkg::MAX_PARAMS) ? slfe_pkg::MAX_PARAMS : param_count;
        for (int i = 0; i < 8; i++)
        begin
            params_masked[i*8 +: 8] = (4'(i) < count_sat) ? param_bytes[i*8 +: 8] : 8'd0;
        end
    end

    assign gap_inc    = (gap_reg == 8'hFF) ? gap_reg : gap_reg + 8'd1;
    assign expect_sum = running_sum_reg - {8'd0, newest_reg} - {8'd0, previous_reg};

    always_comb
    begin
        frame_words = '0;
        if (head_reg[0] == slfe_pkg::HEAD_RESP)
        begin
            if (expect_sum[7:0] != previous_reg || expect_sum[15:8] != newest_reg)
            begin
                frame_status = slfe_pkg::ST_CHECKSUM;
            end
            else
            begin
                frame_words  = {head_reg[4], head_reg[3], head_reg[2], head_reg[1]};
                frame_status = (head_reg[3] != 16'd0) ? slfe_pkg::ST_DEV_ERROR
                                                      : slfe_pkg::ST_OK;
            end
        end
        else if (head_reg[0] == slfe_pkg::HEAD_DATA)
        begin
            frame_status = slfe_pkg::ST_DATA;
        end
        else
        begin
            frame_status = slfe_pkg::ST_OTHER;
        end
    end

    always_comb
    begin
        idle_gap_next    = cfg_write ? cfg_gap : idle_gap_reg;
        waiting_next     = waiting_reg;
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        newest_next      = newest_reg;
        previous_next    = previous_reg;
        head_next        = head_reg;
        gap_next         = gap_reg;
        elapsed_next     = elapsed_reg;
        armed_next       = armed_reg;
        clear_rx         = 1'b0;
        push             = 1'b0;
        push_job         = '0;

        if (accept)
        begin
            unique case (kind)
                slfe_pkg::KIND_SEND:
                begin
                    clear_rx       = 1'b1;
                    gap_next       = '0;
                    elapsed_next   = '0;
                    armed_next     = timeout_ticks;
                    waiting_next   = 1'b1;
                    push           = 1'b1;
                    push_job.is_outcome = slfe_pkg::OUT_TX;
                    push_job.code  = command_code;
                    push_job.count = count_sat;
                    push_job.data  = params_masked;
                end
                slfe_pkg::KIND_RX:
                begin
                    gap_next = '0;
                    if (byte_count_reg < CW'(RX_BUFFER_BYTES))
                    begin
                        for (int w = 0; w < slfe_pkg::HEAD_WORDS; w++)
                        begin
                            if (byte_count_reg[CW-1:1] == (CW-1)'(w))
                            begin
                                if (byte_count_reg[0])
                                begin
                                    head_next[w][15:8] = rx_byte;
                                end
                                else
                                begin
                                    head_next[w][7:0] = rx_byte;
                                end
                            end
                        end
                        running_sum_next = running_sum_reg + {8'd0, rx_byte};
                        previous_next    = newest_reg;
                        newest_next      = rx_byte;
                        byte_count_next  = byte_count_reg + 1'b1;
                    end
                end
                slfe_pkg::KIND_TICK:
                begin
                    gap_next = gap_inc;
                    if (waiting_reg)
                    begin
                        if (elapsed_reg >= armed_reg)
                        begin
                            push                = 1'b1;
                            push_job.is_outcome = slfe_pkg::OUT_OUTCOME;
                            push_job.status     = slfe_pkg::ST_TIMEOUT;
                            waiting_next        = 1'b0;
                            clear_rx            = 1'b1;
                        end
                        else if (byte_count_reg >= CW'(slfe_pkg::FRAME_BYTES)
                                 && gap_inc > idle_gap_reg)
                        begin
                            push                = 1'b1;
                            push_job.is_outcome = slfe_pkg::OUT_OUTCOME;
                            push_job.status     = frame_status;
                            push_job.data       = frame_words;
                            waiting_next        = 1'b0;
                            clear_rx            = 1'b1;
                        end
                        else if (elapsed_reg != 14'h3FFF)
                        begin
                            elapsed_next = elapsed_reg + 14'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (clear_rx)
        begin
            byte_count_next  = '0;
            running_sum_next = '0;
            newest_next      = '0;
            previous_next    = '0;
            for (int w = 0; w < slfe_pkg::HEAD_WORDS; w++)
            begin
                head_next[w] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_gap_reg    <= slfe_pkg::IDLE_GAP_RESET;
            waiting_reg     <= 1'b0;
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            newest_reg      <= '0;
            previous_reg    <= '0;
            for (int w = 0; w < slfe_pkg::HEAD_WORDS; w++)
            begin
                head_reg[w] <= '0;
            end
            gap_reg         <= '0;
            elapsed_reg     <= '0;
            armed_reg       <= '0;
        end
        else
        begin
            idle_gap_reg    <= idle_gap_next;
            waiting_reg     <= waiting_next;
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            newest_reg      <= newest_next;
            previous_reg    <= previous_next;
            head_reg        <= head_next;
            gap_reg         <= gap_next;
            elapsed_reg     <= elapsed_next;
            armed_reg       <= armed_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/slfe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfe_back
// serializes queued jobs into frame bytes and outcome words on the output register
// ----------------------------------------------------------------------------
module slfe_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  slfe_pkg::slfe_job_t      head_job,
    input  slfe_pkg::slfe_q_status_t q_status,
    output logic                     pop,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [slfe_pkg::OUT_DATA_W-1:0] out_data,
    output logic                     out_user,
    output logic                     out_last
);

    localparam logic [4:0] LAST_IDX = 5'(slfe_pkg::FRAME_BYTES - 1);
    localparam logic [4:0] SUM_IDX  = 5'(slfe_pkg::FRAME_BYTES - 2);

    logic        out_valid_reg, out_valid_next;
    logic [slfe_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic        out_user_reg;
    logic        out_last_reg;
    logic [4:0]  idx_reg, idx_next;
    logic [15:0] sum_reg, sum_next;
    logic [4:0]  idx_off;
    logic [7:0]  frame_byte;
    logic        load;

    assign idx_off = idx_reg - 5'd6;

    always_comb
    begin
        case (idx_reg) inside
            5'd0:       frame_byte = slfe_pkg::SYNC0;
            5'd1:       frame_byte = slfe_pkg::SYNC1;
            5'd2:       frame_byte = head_job.code[7:0];
            5'd3:       frame_byte = head_job.code[15:8];
            5'd4:       frame_byte = {4'd0, head_job.count};
            [5'd6:5'd13]: frame_byte = head_job.data[{idx_off[2:0], 3'b000} +: 8];
            5'd22:      frame_byte = sum_reg[7:0];
            5'd23:      frame_byte = sum_reg[15:8];
            default:    frame_byte = 8'd0;
        endcase
    end

    assign load = !q_status.empty && (!out_valid_reg || out_ready);
    assign pop  = load && (head_job.is_outcome || idx_reg == LAST_IDX);

    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (!head_job.is_outcome)
            begin
                idx_next = (idx_reg == LAST_IDX) ? 5'd0 : idx_reg + 5'd1;
                if (idx_reg == 5'd0)
                begin
                    sum_next = {8'd0, frame_byte};
                end
                else if (idx_reg < SUM_IDX)
                begin
                    sum_next = sum_reg + {8'd0, frame_byte};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (load)
        begin
            if (head_job.is_outcome)
            begin
                out_data_reg <= {5'd0, head_job.data, head_job.status, 8'd0};
                out_user_reg <= slfe_pkg::OUT_OUTCOME;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_data_reg <= {5'd0, 64'd0, slfe_pkg::ST_OK, frame_byte};
                out_user_reg <= slfe_pkg::OUT_TX;
                out_last_reg <= (idx_reg == LAST_IDX);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sensor link frame engine: command frames are
// rebuilt byte by byte, response frames are fed back with good, bad, short and
// overlong layouts, and every outcome is predicted from the tick-driven
// receiver and timeout state under several idle gap settings
// ----------------------------------------------------------------------------

typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic [2:0]  status;
    logic [15:0] code;
    logic [15:0] length;
    logic [15:0] result;
    logic [15:0] payload;
} link_result_t;

class link_scoreboard;
    logic [7:0]   idle_gap;
    bit           waiting;
    logic [5:0]   rx_count;
    logic [15:0]  rx_sum;
    logic [7:0]   newest;
    logic [7:0]   previous;
    logic [15:0]  head [5];
    logic [7:0]   gap_age;
    logic [13:0]  elapsed;
    logic [13:0]  armed;
    link_result_t due_results [$];
    int           mismatches;
    int           checked;
    int           sends;
    int           bytes_in;
    int           ticks;
    int           outcomes [6];

    function new();
        idle_gap = slfe_pkg::IDLE_GAP_RESET;
        waiting  = 1'b0;
        gap_age  = '0;
        elapsed  = '0;
        armed    = '0;
        clear_rx();
    endfunction

    function void clear_rx();
        rx_count = '0;
        rx_sum   = '0;
        newest   = '0;
        previous = '0;
        foreach (head[i])
            head[i] = '0;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void end_response(bit timed_out);
        link_result_t r;
        logic [15:0]  want_sum;
        r = '0;
        r.kind = slfe_pkg::OUT_OUTCOME;
        r.last = 1'b1;
        if (timed_out)
            r.status = slfe_pkg::ST_TIMEOUT;
        else if (head[0] == slfe_pkg::HEAD_RESP) begin
            want_sum = rx_sum - {8'd0, newest} - {8'd0, previous};
            if (want_sum[7:0] != previous || want_sum[15:8] != newest)
                r.status = slfe_pkg::ST_CHECKSUM;
            else begin
                r.code    = head[1];
                r.length  = head[2];
                r.result  = head[3];
                r.payload = head[4];
                r.status  = (head[3] != 16'd0) ? slfe_pkg::ST_DEV_ERROR : slfe_pkg::ST_OK;
            end
        end
        else if (head[0] == slfe_pkg::HEAD_DATA)
            r.status = slfe_pkg::ST_DATA;
        else
            r.status = slfe_pkg::ST_OTHER;
        outcomes[r.status]++;
        due_results.push_back(r);
        waiting = 1'b0;
        clear_rx();
    endfunction

    function void note_word(logic [1:0] kind, logic [15:0] code, logic [3:0] count,
                            logic [63:0] params, logic [13:0] tmo, logic [7:0] rxb);
        logic [7:0]   frame [slfe_pkg::FRAME_BYTES];
        logic [15:0]  sum;
        logic [3:0]   n;
        link_result_t r;
        case (kind)
            slfe_pkg::KIND_SEND:
            begin
                sends++;
                n = (count > slfe_pkg::MAX_PARAMS) ? slfe_pkg::MAX_PARAMS : count;
                foreach (frame[i])
                    frame[i] = '0;
                frame[0] = slfe_pkg::SYNC0;
                frame[1] = slfe_pkg::SYNC1;
                frame[2] = code[7:0];
                frame[3] = code[15:8];
                frame[4] = {4'd0, n};
                for (int i = 0; i < n; i++)
                    frame[6 + i] = params[8 * i +: 8];
                sum = '0;
                for (int i = 0; i < slfe_pkg::FRAME_BYTES - 2; i++)
                    sum += {8'd0, frame[i]};
                frame[slfe_pkg::FRAME_BYTES - 2] = sum[7:0];
                frame[slfe_pkg::FRAME_BYTES - 1] = sum[15:8];
                for (int i = 0; i < slfe_pkg::FRAME_BYTES; i++)
                begin
                    r = '0;
                    r.kind   = slfe_pkg::OUT_TX;
                    r.tx     = frame[i];
                    r.last   = (i == slfe_pkg::FRAME_BYTES - 1);
                    r.status = slfe_pkg::ST_OK;
                    due_results.push_back(r);
                end
                clear_rx();
                gap_age = '0;
                elapsed = '0;
                armed   = tmo;
                waiting = 1'b1;
            end
            slfe_pkg::KIND_RX:
            begin
                bytes_in++;
                gap_age = '0;
                if (rx_count < slfe_pkg::RX_BUFFER_BYTES_DEF)
                begin
                    if (rx_count < slfe_pkg::HEAD_BYTES)
                    begin
                        if (rx_count[0])
                            head[rx_count[3:1]][15:8] = rxb;
                        else
                            head[rx_count[3:1]][7:0] = rxb;
                    end
                    rx_sum   = rx_sum + {8'd0, rxb};
                    previous = newest;
                    newest   = rxb;
                    rx_count = rx_count + 6'd1;
                end
            end
            slfe_pkg::KIND_TICK:
            begin
                ticks++;
                if (gap_age != 8'hFF)
                    gap_age++;
                if (waiting)
                begin
                    if (elapsed >= armed)
                        end_response(1'b1);
                    else if (rx_count >= slfe_pkg::FRAME_BYTES && gap_age > idle_gap)
                        end_response(1'b0);
                    else if (elapsed != 14'h3FFF)
                        elapsed++;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void check_result(link_result_t got);
        link_result_t w;
        if (due_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d tx %02h last %0d status %0d %04h %04h %04h %04h",
                         got.kind, got.tx, got.last, got.status,
                         got.code, got.length, got.result, got.payload);
            return;
        end
        w = due_results.pop_front();
        checked++;
        if (got.kind !== w.kind || got.tx !== w.tx || got.last !== w.last ||
            got.status !== w.status || got.code !== w.code || got.length !== w.length ||
            got.result !== w.result || got.payload !== w.payload)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $write("mismatch: expected kind %0d tx %02h last %0d status %0d %04h %04h %04h %04h",
                       w.kind, w.tx, w.last, w.status, w.code, w.length, w.result, w.payload);
                $display(", got kind %0d tx %02h last %0d status %0d %04h %04h %04h %04h",
                         got.kind, got.tx, got.last, got.status,
                         got.code, got.length, got.result, got.payload);
            end
        end
    endfunction
endclass

module tb_top;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int         PHASES     = 5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [slfe_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [slfe_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic m_tlast;

    link_scoreboard sb;
    bit             steady = 1'b0;
    int             words_sent = 0;
    logic [7:0]     gap_plan [PHASES];

    sensor_link_frame_engine_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    task automatic push_word(logic [1:0] kind, logic [15:0] code, logic [3:0] count,
                             logic [63:0] params, logic [13:0] tmo, logic [7:0] rxb);
        int wait_cycles;
        wait_cycles = steady ? 0 : $urandom_range(0, 4);
        if (wait_cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (wait_cycles) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, rxb, tmo, params, count, code};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(kind, code, count, params, tmo, rxb);
        if (kind != KIND_SPARE)
            words_sent++;
    endtask

    task automatic push_send(logic [15:0] code, logic [3:0] count, logic [63:0] params,
                             logic [13:0] tmo);
        push_word(slfe_pkg::KIND_SEND, code, count, params, tmo, 8'($urandom));
    endtask

    task automatic push_rx(logic [7:0] b);
        push_word(slfe_pkg::KIND_RX, 16'($urandom), 4'($urandom), {$urandom, $urandom},
                  14'($urandom), b);
    endtask

    task automatic push_tick();
        push_word(slfe_pkg::KIND_TICK, 16'($urandom), 4'($urandom), {$urandom, $urandom},
                  14'($urandom), 8'($urandom));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one command with a response of a randomly chosen layout, then ticks
    task automatic run_exchange();
        logic [7:0]  resp [30];
        logic [15:0] sum;
        int          flavor;
        int          len;
        flavor = $urandom_range(0, 7);
        steady = ($urandom_range(0, 4) == 0);
        push_send(16'($urandom), ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                              : 4'($urandom_range(0, 8)),
                  {$urandom, $urandom}, 14'($urandom_range(8, 60)));
        foreach (resp[i])
            resp[i] = 8'($urandom);
        len = slfe_pkg::FRAME_BYTES;
        if (flavor == 4)
        begin
            resp[0] = slfe_pkg::HEAD_DATA[7:0];
            resp[1] = slfe_pkg::HEAD_DATA[15:8];
        end
        else if (flavor != 5)
        begin
            resp[0] = slfe_pkg::HEAD_RESP[7:0];
            resp[1] = slfe_pkg::HEAD_RESP[15:8];
            if (flavor == 2)
                resp[7] = 8'($urandom_range(1, 255));
            else if (flavor != 3 && flavor != 6)
            begin
                resp[6] = '0;
                resp[7] = '0;
            end
            sum = '0;
            for (int i = 0; i < slfe_pkg::FRAME_BYTES - 2; i++)
                sum += {8'd0, resp[i]};
            resp[22] = sum[7:0];
            resp[23] = sum[15:8];
            if (flavor == 3)
                resp[22 + $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
            if (flavor == 6)
                len = $urandom_range(1, slfe_pkg::FRAME_BYTES - 1);
            if (flavor == 7)
                len = $urandom_range(slfe_pkg::FRAME_BYTES + 1, 30);
        end
        for (int i = 0; i < len; i++)
        begin
            push_rx(resp[i]);
            if ($urandom_range(0, 9) == 0)
                push_tick();
        end
        for (int i = 0; i < 80 && sb.waiting; i++)
            push_tick();
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            push_word(2'($urandom_range(0, 3)), 16'($urandom), 4'($urandom),
                      {$urandom, $urandom}, 14'($urandom), 8'($urandom));
    endtask

    always @(posedge clk)
    begin : watch_results
        link_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind    = m_tuser[0];
            got.tx      = m_tdata[7:0];
            got.last    = m_tlast;
            got.status  = m_tdata[10:8];
            got.code    = m_tdata[26:11];
            got.length  = m_tdata[42:27];
            got.result  = m_tdata[58:43];
            got.payload = m_tdata[74:59];
            sb.check_result(got);
        end
    end

    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        #2000000;
        $display("run timed out with %0d results outstanding", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        gap_plan = '{8'd0, 8'd255, 8'd1, 8'd7, 8'd0};
        gap_plan[PHASES - 1] = 8'($urandom_range(2, 12));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle gap at its reset value
        push_tick();
        push_rx(8'h00);
        push_rx(8'hFF);
        push_word(KIND_SPARE, 16'hFFFF, 4'hF, '1, 14'h3FFF, 8'hFF);
        push_word(slfe_pkg::KIND_SEND, 16'hFFFF, 4'hF, '1, 14'd0, 8'hFF);
        push_tick();
        push_send(16'h0000, 4'd0, '0, 14'h3FFF);
        push_send(16'($urandom), slfe_pkg::MAX_PARAMS, {$urandom, $urandom}, 14'd2);
        repeat (3) push_tick();

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            cfg_valid <= 1'b1;
            cfg_data  <= gap_plan[p];
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            sb.idle_gap = gap_plan[p];
            while (words_sent < 10 + (p + 1) * 82)
            begin
                if ($urandom_range(0, 3) == 0)
                    run_noise();
                else
                    run_exchange();
                if ($urandom_range(0, 5) == 0)
                    settle();
            end
        end

        settle();
        repeat (6) @(posedge clk);
        $display("covered %0d words: %0d commands, %0d received bytes, %0d ticks",
                 words_sent, sb.sends, sb.bytes_in, sb.ticks);
        $display("over %0d gap settings; checked %0d results", PHASES + 1, sb.checked);
        $display("outcomes ok %0d, checksum %0d, device error %0d, timeout %0d, data %0d, other %0d",
                 sb.outcomes[slfe_pkg::ST_OK], sb.outcomes[slfe_pkg::ST_CHECKSUM],
                 sb.outcomes[slfe_pkg::ST_DEV_ERROR], sb.outcomes[slfe_pkg::ST_TIMEOUT],
                 sb.outcomes[slfe_pkg::ST_DATA], sb.outcomes[slfe_pkg::ST_OTHER]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
